// ===== hw/rtl/wildcard_read_deduplicator_defines.svh =====
// assertion macros shared by the deduplicator rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef WILDCARD_READ_DEDUPLICATOR_DEFINES_SVH
`define WILDCARD_READ_DEDUPLICATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WDR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WDR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/wdr_pkg.sv =====
// types and constants of the wildcard read deduplicator
// no dependencies
package wdr_pkg;

	localparam int unsigned BASE_W  = 3;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned NCNT_W  = 9;
	localparam logic [NCNT_W-1:0] N_SAT = 9'd256;
	localparam logic [NCNT_W-1:0] N_LIMIT_RST = 9'd256;

	// result codes
	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_DUP      = 3'd1,
		ST_MANY_N   = 3'd2,
		ST_FULL     = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	// one base travelling down the cell chain, with the running search result
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [BASE_W-1:0] base;
		logic              found;
		logic [ID_W-1:0]   matched;
	} tok_t;

	// codes 4 to 7 all count as the N wildcard
	function automatic logic is_wild(input logic [BASE_W-1:0] b);
		return b[BASE_W-1];
	endfunction

endpackage

// ===== hw/rtl/wdr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module wdr_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/wdr_cell.sv =====
// one slot of the read table: stored bases, length, id and match flag
// depends on wdr_pkg and wdr_ram
module wdr_cell #(
	parameter int MAX_LEN = 256,
	localparam int PW = $clog2(MAX_LEN + 2),
	localparam int LW = $clog2(MAX_LEN + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wdr_pkg::tok_t            tok_in,
	input  logic [PW-1:0]            pos_in,
	input  logic                     fill_sel,
	input  logic                     store_en,
	input  logic [LW-1:0]            store_len,
	input  logic [wdr_pkg::ID_W-1:0] store_id,
	output wdr_pkg::tok_t            tok_out,
	output logic [PW-1:0]            pos_out
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	wdr_pkg::tok_t                tok_s1;
	logic [PW-1:0]                pos_s1;
	logic                         stored_q;
	logic                         match_q;
	logic [LW-1:0]                len_q;
	logic [wdr_pkg::ID_W-1:0]     id_q;
	logic [wdr_pkg::BASE_W-1:0]   rd_base;
	logic                         in_range_in;
	logic                         in_range;
	logic                         base_ok;
	logic                         match_now;
	logic                         hit;

	assign in_range_in = pos_in < PW'(MAX_LEN);

	// bases of the read in flight land in the next free slot
	wdr_ram #(
		.WIDTH (wdr_pkg::BASE_W),
		.DEPTH (MAX_LEN)
	) u_bases (
		.clk   (clk),
		.we    (tok_in.valid && fill_sel && in_range_in),
		.waddr (pos_in[AW-1:0]),
		.wdata (tok_in.base),
		.raddr (pos_in[AW-1:0]),
		.rdata (rd_base)
	);

	always_comb begin
		in_range  = pos_s1 < PW'(MAX_LEN);
		base_ok   = (rd_base == tok_s1.base) || wdr_pkg::is_wild(rd_base)
			|| wdr_pkg::is_wild(tok_s1.base);
		match_now = match_q && (pos_s1 < PW'(len_q)) && base_ok;
		hit       = stored_q && tok_s1.last && in_range && match_now
			&& (PW'(len_q) == pos_s1 + PW'(1));
		tok_out         = tok_s1;
		tok_out.found   = tok_s1.found || hit;
		tok_out.matched = tok_s1.found ? tok_s1.matched : id_q;
		pos_out         = pos_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1   <= '0;
			stored_q <= 1'b0;
			match_q  <= 1'b1;
		end else begin
			tok_s1 <= tok_in;
			if (store_en && fill_sel) begin
				stored_q <= 1'b1;
			end
			if (tok_s1.valid) begin
				if (tok_s1.last) begin
					match_q <= 1'b1;
				end else if (in_range) begin
					match_q <= match_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_in;
		if (store_en && fill_sel) begin
			len_q <= store_len;
			id_q  <= store_id;
		end
	end

endmodule

// ===== hw/rtl/wildcard_read_deduplicator.sv =====
// wildcard read deduplicator top level: entry counters, cell chain, verdict
// depends on wdr_pkg, wdr_cell and wildcard_read_deduplicator_defines.svh
//
//  channel   signals                                  direction
//  in        in_valid in_ready base last              into block
//  out       out_valid out_ready status read_number   out of block
//            matched_read missing_count
//  cfg       cfg_wr_en cfg_wr_data (n limit)          into block
//
// bases of a read enter one per cycle while in_ready is high; a base hops
// one cell per cycle. the result is complete once the last base has crossed
// the whole cell chain, and goes to the output register when that is free.
// the next read is taken once the result is in the output register.
// reset empties the table at once through the per-cell stored flags.
`include "wildcard_read_deduplicator_defines.svh"

module wildcard_read_deduplicator #(
	parameter int MAX_READS = 64,
	parameter int MAX_LEN   = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wdr_pkg::BASE_W-1:0]   base,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [wdr_pkg::ID_W-1:0]     read_number,
	output logic [wdr_pkg::ID_W-1:0]     matched_read,
	output logic [wdr_pkg::NCNT_W-1:0]   missing_count,
	input  logic                         cfg_wr_en,
	input  logic [wdr_pkg::NCNT_W-1:0]   cfg_wr_data
);

	localparam int PW = $clog2(MAX_LEN + 2);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int SW = $clog2(MAX_READS + 1);

	wdr_pkg::tok_t                tok_c [MAX_READS+1];
	logic [PW-1:0]                pos_c [MAX_READS+1];
	logic [MAX_READS-1:0]         fill_sel;

	logic [PW-1:0]                pos_q;
	logic [wdr_pkg::NCNT_W-1:0]   n_seen_q;
	logic [wdr_pkg::NCNT_W-1:0]   n_limit_q;
	logic [SW-1:0]                slots_used_q;
	logic [wdr_pkg::ID_W-1:0]     read_counter_q;
	logic                         busy_q;
	logic                         done_q;
	logic                         found_q;
	logic [wdr_pkg::ID_W-1:0]     matched_q;
	logic                         out_valid_q;
	wdr_pkg::status_t             status_q;
	logic [wdr_pkg::ID_W-1:0]     read_number_q;
	logic [wdr_pkg::ID_W-1:0]     matched_read_q;
	logic [wdr_pkg::NCNT_W-1:0]   missing_count_q;

	logic                         in_xfer;
	logic                         load;
	logic                         store_en;
	wdr_pkg::status_t             verdict;

	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;
	assign load     = done_q && (!out_valid_q || out_ready);
	assign store_en = load && (verdict == wdr_pkg::ST_NEW);

	always_comb begin
		tok_c[0].valid   = in_xfer;
		tok_c[0].last    = last;
		tok_c[0].base    = base;
		tok_c[0].found   = 1'b0;
		tok_c[0].matched = '0;
		pos_c[0]         = pos_q;
	end

	always_comb begin
		if (pos_q > PW'(MAX_LEN)) begin
			verdict = wdr_pkg::ST_TOO_LONG;
		end else if (n_seen_q > n_limit_q) begin
			verdict = wdr_pkg::ST_MANY_N;
		end else if (found_q) begin
			verdict = wdr_pkg::ST_DUP;
		end else if (slots_used_q < SW'(MAX_READS)) begin
			verdict = wdr_pkg::ST_NEW;
		end else begin
			verdict = wdr_pkg::ST_FULL;
		end
	end

	for (genvar k = 0; k < MAX_READS; k++) begin : g_cell
		assign fill_sel[k] = slots_used_q == SW'(k);

		wdr_cell #(
			.MAX_LEN (MAX_LEN)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tok_c[k]),
			.pos_in    (pos_c[k]),
			.fill_sel  (fill_sel[k]),
			.store_en  (store_en),
			.store_len (pos_q[LW-1:0]),
			.store_id  (read_counter_q),
			.tok_out   (tok_c[k+1]),
			.pos_out   (pos_c[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			n_seen_q       <= '0;
			n_limit_q      <= wdr_pkg::N_LIMIT_RST;
			slots_used_q   <= '0;
			read_counter_q <= '0;
			busy_q         <= 1'b0;
			done_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				n_limit_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				pos_q <= (pos_q < PW'(MAX_LEN)) ? pos_q + PW'(1) : PW'(MAX_LEN + 1);
				if (wdr_pkg::is_wild(base) && (n_seen_q < wdr_pkg::N_SAT)) begin
					n_seen_q <= n_seen_q + wdr_pkg::NCNT_W'(1);
				end
				if (last) begin
					busy_q <= 1'b1;
				end
			end
			// last base left the final cell: the search result is complete
			if (tok_c[MAX_READS].valid && tok_c[MAX_READS].last) begin
				done_q <= 1'b1;
			end
			if (load) begin
				done_q         <= 1'b0;
				busy_q         <= 1'b0;
				out_valid_q    <= 1'b1;
				pos_q          <= '0;
				n_seen_q       <= '0;
				read_counter_q <= read_counter_q + wdr_pkg::ID_W'(1);
				if (store_en) begin
					slots_used_q <= slots_used_q + SW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_c[MAX_READS].valid && tok_c[MAX_READS].last) begin
			found_q   <= tok_c[MAX_READS].found;
			matched_q <= tok_c[MAX_READS].matched;
		end
		if (load) begin
			status_q        <= verdict;
			read_number_q   <= read_counter_q;
			matched_read_q  <= (verdict == wdr_pkg::ST_DUP) ? matched_q : '0;
			missing_count_q <= n_seen_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign read_number   = read_number_q;
	assign matched_read  = matched_read_q;
	assign missing_count = missing_count_q;

	`WDR_ASSERT_IMP(a_slots_bound, 1'b1, slots_used_q <= SW'(MAX_READS), "slot count overflow")
	`WDR_ASSERT_IMP(a_done_busy, done_q, busy_q && !in_ready, "verdict pending while idle")
	`WDR_ASSERT_IMP(a_chain_busy, tok_c[MAX_READS].valid && tok_c[MAX_READS].last, busy_q,
		"read end left chain while idle")
	`WDR_ASSERT_NXT(a_store_count, store_en, slots_used_q == $past(slots_used_q) + SW'(1),
		"store did not take a slot")
	`WDR_ASSERT_NXT(a_load_clears, load, !done_q && pos_q == '0 && out_valid_q,
		"read state not cleared after result")

endmodule

// ===== dv/wdr_read_checker.sv =====
// read-verdict checker for the wildcard read deduplicator
// watches the base, result and register ports, keeps its own copy of the read table
// depends on wdr_pkg
module wdr_read_checker #(
	parameter int MAX_READS = 64,
	parameter int MAX_LEN   = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [wdr_pkg::BASE_W-1:0]   base,
	input  logic                         last,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [2:0]                   status,
	input  logic [wdr_pkg::ID_W-1:0]     read_number,
	input  logic [wdr_pkg::ID_W-1:0]     matched_read,
	input  logic [wdr_pkg::NCNT_W-1:0]   missing_count,
	input  logic                         cfg_wr_en,
	input  logic [wdr_pkg::NCNT_W-1:0]   cfg_wr_data,
	output int                           pending,
	output int                           fail_count
);

	typedef struct packed {
		wdr_pkg::status_t              status;
		logic [wdr_pkg::ID_W-1:0]      read_number;
		logic [wdr_pkg::ID_W-1:0]      matched_read;
		logic [wdr_pkg::NCNT_W-1:0]    missing_count;
	} verdict_t;

	localparam int WILD_SAT = 256;

	logic [wdr_pkg::BASE_W-1:0] tbl_base [MAX_READS][MAX_LEN];
	int                         tbl_len  [MAX_READS];
	logic [wdr_pkg::ID_W-1:0]   tbl_id   [MAX_READS];
	bit                         alive    [MAX_READS];
	int                         n_slots;
	int                         pos_cnt;
	int                         wild_cnt;
	logic [wdr_pkg::ID_W-1:0]   read_ctr;
	int                         n_limit;
	verdict_t                   verdicts_due [$];

	function automatic bit wild_code(input logic [wdr_pkg::BASE_W-1:0] b);
		return b >= 3'd4;
	endfunction

	function automatic void restart_read();
		pos_cnt = 0;
		wild_cnt = 0;
		for (int s = 0; s < MAX_READS; s++)
			alive[s] = 1'b1;
	endfunction

	// one accepted base: extend the running match, and on the final base classify the read
	function automatic void take_base(input logic [wdr_pkg::BASE_W-1:0] b, input logic fin);
		verdict_t v;
		int       len;
		bit       hit;
		hit = 1'b0;
		v.matched_read = '0;
		if (pos_cnt < MAX_LEN) begin
			if (n_slots < MAX_READS)
				tbl_base[n_slots][pos_cnt] = b;
			for (int s = 0; s < n_slots; s++) begin
				if (alive[s]) begin
					if (pos_cnt >= tbl_len[s])
						alive[s] = 1'b0;
					else if (tbl_base[s][pos_cnt] != b && !wild_code(tbl_base[s][pos_cnt])
							&& !wild_code(b))
						alive[s] = 1'b0;
				end
			end
			pos_cnt++;
		end else begin
			pos_cnt = MAX_LEN + 1;
		end
		if (wild_code(b) && wild_cnt < WILD_SAT)
			wild_cnt++;
		if (!fin)
			return;

		len = pos_cnt;
		if (len > MAX_LEN) begin
			v.status = wdr_pkg::ST_TOO_LONG;
		end else if (wild_cnt > n_limit) begin
			v.status = wdr_pkg::ST_MANY_N;
		end else begin
			// first stored read in insertion order wins
			for (int s = 0; s < n_slots && !hit; s++) begin
				if (alive[s] && tbl_len[s] == len) begin
					hit = 1'b1;
					v.matched_read = tbl_id[s];
				end
			end
			if (hit) begin
				v.status = wdr_pkg::ST_DUP;
			end else if (n_slots < MAX_READS) begin
				tbl_len[n_slots] = len;
				tbl_id[n_slots] = read_ctr;
				n_slots++;
				v.status = wdr_pkg::ST_NEW;
			end else begin
				v.status = wdr_pkg::ST_FULL;
			end
		end
		v.read_number = read_ctr;
		v.missing_count = 9'(wild_cnt);
		verdicts_due.insert(verdicts_due.size(), v);
		read_ctr++;
		restart_read();
	endfunction

	always @(posedge clk) begin
		verdict_t exp_v;
		if (!arst_n) begin
			for (int s = 0; s < MAX_READS; s++) begin
				tbl_len[s] = 0;
				tbl_id[s] = '0;
			end
			n_slots = 0;
			read_ctr = '0;
			n_limit = int'(wdr_pkg::N_LIMIT_RST);
			restart_read();
			verdicts_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result transfer with no read outstanding: read_number %0d",
						read_number);
					fail_count++;
				end else begin
					exp_v = verdicts_due.pop_front();
					if (status !== exp_v.status) begin
						$error("status: expected %0d, got %0d", exp_v.status, status);
						fail_count++;
					end
					if (read_number !== exp_v.read_number) begin
						$error("read_number: expected %0d, got %0d", exp_v.read_number,
							read_number);
						fail_count++;
					end
					if (matched_read !== exp_v.matched_read) begin
						$error("matched_read: expected %0d, got %0d", exp_v.matched_read,
							matched_read);
						fail_count++;
					end
					if (missing_count !== exp_v.missing_count) begin
						$error("missing_count: expected %0d, got %0d", exp_v.missing_count,
							missing_count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				take_base(base, last);
			if (cfg_wr_en)
				n_limit = int'(cfg_wr_data);
		end
		pending = verdicts_due.size();
	end

endmodule

// ===== dv/tb_wildcard_read_deduplicator.sv =====
// top of the wildcard read deduplicator testbench: clock, reset, read stimulus, verdict
// depends on wdr_pkg, wildcard_read_deduplicator and wdr_read_checker
module tb_wildcard_read_deduplicator;

	localparam int MAX_READS    = 64;
	localparam int MAX_LEN      = 256;
	localparam int LIB_DEPTH    = 128;
	localparam int LIB_W        = 32;
	localparam int RANDOM_ITEMS = 950;
	localparam int PHASE_ITEMS  = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 600000;

	localparam logic [2:0] BASE_A = 3'd0;
	localparam logic [2:0] BASE_C = 3'd1;
	localparam logic [2:0] BASE_G = 3'd2;
	localparam logic [2:0] BASE_T = 3'd3;
	localparam logic [2:0] BASE_N = 3'd4;
	localparam logic [2:0] N_ALT1 = 3'd5;
	localparam logic [2:0] N_ALT2 = 3'd6;
	localparam logic [2:0] N_ALT3 = 3'd7;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [wdr_pkg::BASE_W-1:0]   base;
	logic                         last;
	logic                         out_valid;
	logic                         out_ready;
	logic [2:0]                   status;
	logic [wdr_pkg::ID_W-1:0]     read_number;
	logic [wdr_pkg::ID_W-1:0]     matched_read;
	logic [wdr_pkg::NCNT_W-1:0]   missing_count;
	logic                         cfg_wr_en;
	logic [wdr_pkg::NCNT_W-1:0]   cfg_wr_data;
	int                           pending;
	int                           fail_count;

	logic [2:0] rd_buf  [MAX_LEN+8];
	logic [2:0] lib_seq [LIB_DEPTH][LIB_W];
	int         lib_len [LIB_DEPTH];
	int         lib_cnt;
	int         reads_sent;
	int         cycle_cnt;
	bit         gaps_on;
	bit         held_off;

	wildcard_read_deduplicator #(
		.MAX_READS(MAX_READS),
		.MAX_LEN  (MAX_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.base         (base),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_number  (read_number),
		.matched_read (matched_read),
		.missing_count(missing_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	wdr_read_checker #(
		.MAX_READS(MAX_READS),
		.MAX_LEN  (MAX_LEN)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.base         (base),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_number  (read_number),
		.matched_read (matched_read),
		.missing_count(missing_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// entered at a falling edge, returns at the falling edge after the transfer
	task automatic send_base(input logic [2:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		last <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_read(input int len);
		int slot;
		for (int i = 0; i < len; i++)
			send_base(rd_buf[i], i == len - 1);
		// short reads are kept so later reads can replay them
		if (len <= LIB_W) begin
			slot = lib_cnt % LIB_DEPTH;
			lib_len[slot] = len;
			for (int i = 0; i < len; i++)
				lib_seq[slot][i] = rd_buf[i];
			lib_cnt++;
		end
		reads_sent++;
	endtask

	task automatic send_short(input int len, input logic [2:0] b0, input logic [2:0] b1,
			input logic [2:0] b2, input logic [2:0] b3);
		rd_buf[0] = b0;
		rd_buf[1] = b1;
		rd_buf[2] = b2;
		rd_buf[3] = b3;
		send_read(len);
	endtask

	// only once every result is back and the chain has drained
	task automatic write_cfg(input logic [8:0] v);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (MAX_READS + 8) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic gen_read(output int len);
		int         kind;
		int         src;
		int         pos;
		logic [1:0] step;
		kind = $urandom_range(0, 99);
		if (kind < 50 || lib_cnt == 0) begin
			// fresh read, mostly plain bases
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, LIB_W) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				rd_buf[i] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(BASE_N, N_ALT3))
					: 3'($urandom_range(BASE_A, BASE_T));
		end else if (kind < 90) begin
			src = $urandom_range(0, (lib_cnt < LIB_DEPTH ? lib_cnt : LIB_DEPTH) - 1);
			len = lib_len[src];
			for (int i = 0; i < len; i++)
				rd_buf[i] = lib_seq[src][i];
			if (kind < 80) begin
				// replay with some positions turned into wildcards
				repeat ($urandom_range(0, 2))
					rd_buf[$urandom_range(0, len - 1)] = 3'($urandom_range(BASE_N, N_ALT3));
			end else begin
				// near miss: one base off or length off by one
				case ($urandom_range(0, 2))
					0: begin
						if (len < LIB_W) begin
							rd_buf[len] = 3'($urandom_range(BASE_A, BASE_T));
							len++;
						end
					end
					1: begin
						if (len > 1)
							len--;
					end
					default: begin
						pos = $urandom_range(0, len - 1);
						step = 2'($urandom_range(1, 3));
						rd_buf[pos] = {1'b0, rd_buf[pos][1:0] + step};
					end
				endcase
			end
		end else begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				rd_buf[i] = 3'($urandom_range(BASE_A, N_ALT3));
		end
	endtask

	// result side: random stalls, plus one long hold-off while bases keep coming
	initial begin
		int run;
		int roll;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && reads_sent >= 20) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					out_ready <= 1'b1;
					run = $urandom_range(1, 40);
				end else if (roll < 95) begin
					out_ready <= 1'b0;
					run = $urandom_range(1, 4);
				end else begin
					out_ready <= 1'b0;
					run = $urandom_range(20, 80);
				end
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int         phase;
		int         len;
		int         phase_items;
		int         rand_items;
		logic [8:0] limit;
		in_valid = 1'b0;
		base = BASE_A;
		last = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: exact hits, wildcard hits in the new read, all wildcard codes
		send_short(1, BASE_A, BASE_A, BASE_A, BASE_A);
		send_short(1, BASE_A, BASE_A, BASE_A, BASE_A);
		send_short(1, BASE_N, BASE_A, BASE_A, BASE_A);
		send_short(3, BASE_C, BASE_G, BASE_T, BASE_A);
		send_short(3, BASE_C, N_ALT3, BASE_T, BASE_A);
		send_short(3, BASE_G, BASE_G, BASE_G, BASE_A);
		send_short(2, BASE_A, BASE_C, BASE_A, BASE_A);
		send_short(2, N_ALT1, N_ALT2, BASE_A, BASE_A);
		// no wildcard allowed at all
		write_cfg(9'd0);
		send_short(2, BASE_T, BASE_N, BASE_A, BASE_A);
		send_short(2, BASE_T, BASE_T, BASE_A, BASE_A);
		send_short(4, BASE_A, BASE_C, BASE_G, BASE_T);

		phase = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case (phase % 8)
				0, 5:    limit = 9'd256;
				1:       limit = 9'd0;
				2:       limit = 9'd1;
				3:       limit = 9'd255;
				6:       limit = 9'd2;
				default: limit = 9'($urandom_range(0, 256));
			endcase
			write_cfg(limit);
			gaps_on = 1'b1;
			if (phase == 3) begin
				// one base too long, all wildcards so the count saturates
				for (int i = 0; i <= MAX_LEN; i++)
					rd_buf[i] = 3'($urandom_range(BASE_N, N_ALT3));
				send_read(MAX_LEN + 1);
				rand_items += MAX_LEN + 1;
			end
			if (phase == 5) begin
				for (int i = 0; i < MAX_LEN; i++)
					rd_buf[i] = 3'($urandom_range(BASE_A, BASE_T));
				send_read(MAX_LEN);
				repeat (12) rd_buf[$urandom_range(0, MAX_LEN - 1)] = BASE_N;
				send_read(MAX_LEN);
				rand_items += 2 * MAX_LEN;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS && rand_items < RANDOM_ITEMS) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				gen_read(len);
				send_read(len);
				phase_items += len;
				rand_items += len;
			end
			phase++;
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (MAX_READS + 16) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== wildcard_read_deduplicator.f =====
+incdir+hw/rtl
hw/rtl/wdr_pkg.sv
hw/rtl/wdr_ram.sv
hw/rtl/wdr_cell.sv
hw/rtl/wildcard_read_deduplicator.sv
dv/wdr_read_checker.sv
dv/tb_wildcard_read_deduplicator.sv
